/* sv/dual_channel_trimmed_mean_macros.svh */
// assertion macros for the dual channel trimmed mean block
`ifndef DUAL_CHANNEL_TRIMMED_MEAN_MACROS_SVH
`define DUAL_CHANNEL_TRIMMED_MEAN_MACROS_SVH

// same-cycle implication, checked out of reset
`define DCTM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DCTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dctm_pkg.sv */
// shared types for the dual channel trimmed mean block
`default_nettype none

package dctm_pkg;

    // pipeline control from the top level to each channel
    typedef struct packed {
        logic acc_en;   // input row is folded into the accumulators
        logic last;     // that row closes the window
        logic fin_ld;   // window totals move into the final stage
        logic diff_ld;  // trimmed sum stage loads
        logic out_ld;   // result register loads
    } t_pipe_ctl;

endpackage

`default_nettype wire

/* sv/dctm_if.sv */
// valid/ready stream interfaces for sample rows and average results
`default_nettype none

interface dctm_sample_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] pulse_sample;
    logic [SAMPLE_BITS-1:0] temp_sample;

    modport source (output valid, output pulse_sample, output temp_sample, input ready);
    modport sink   (input valid, input pulse_sample, input temp_sample, output ready);
endinterface

interface dctm_result_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] pulse_average;
    logic [SAMPLE_BITS-1:0] temp_average;

    modport source (output valid, output pulse_average, output temp_average, input ready);
    modport sink   (input valid, input pulse_average, input temp_average, output ready);
endinterface

`default_nettype wire

/* sv/dctm_chan.sv */
// one channel: window sum and extremes, trimmed sum, reciprocal divide
`default_nettype none

module dctm_chan import dctm_pkg::*; #(
    parameter int WINDOW_LENGTH = 12,
    parameter int SAMPLE_BITS   = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_pipe_ctl              i_ctl,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic      [SAMPLE_BITS-1:0] o_average
);

    // sum width holds a full window of samples
    localparam int SUMW    = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
    localparam int DIVISOR = WINDOW_LENGTH - 2;
    // exact floor division by a constant: x * ceil(2^k / d) >> k
    localparam int RK      = SUMW + $clog2(DIVISOR);
    localparam int RW      = SUMW + 1;
    localparam int PW      = SUMW + RW;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RK) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

    logic [SUMW-1:0]        r_sum, n_sum;
    logic [SAMPLE_BITS-1:0] r_min, n_min;
    logic [SAMPLE_BITS-1:0] r_max, n_max;
    logic [SUMW-1:0]        r_fin_sum;
    logic [SAMPLE_BITS-1:0] r_fin_min;
    logic [SAMPLE_BITS-1:0] r_fin_max;
    logic [SUMW-1:0]        r_diff;
    logic [PW-1:0]          r_prod;

    // fold the sample into the running totals
    always_comb begin
        n_sum = r_sum + SUMW'(i_sample);
        n_min = (i_sample < r_min) ? i_sample : r_min;
        n_max = (i_sample > r_max) ? i_sample : r_max;
    end

    // window accumulators, cleared when the window closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_min <= '1;
            r_max <= '0;
        end else if (i_ctl.acc_en) begin
            if (i_ctl.last) begin
                r_sum <= '0;
                r_min <= '1;
                r_max <= '0;
            end else begin
                r_sum <= n_sum;
                r_min <= n_min;
                r_max <= n_max;
            end
        end
    end

    // window totals, trimmed sum and scaled quotient
    always_ff @(posedge i_clk) begin
        if (i_ctl.fin_ld) begin
            r_fin_sum <= n_sum;
            r_fin_min <= n_min;
            r_fin_max <= n_max;
        end
        if (i_ctl.diff_ld) begin
            r_diff <= r_fin_sum - SUMW'(r_fin_min) - SUMW'(r_fin_max);
        end
        if (i_ctl.out_ld) begin
            r_prod <= PW'(r_diff) * PW'(RECIP);
        end
    end

    assign o_average = r_prod[RK +: SAMPLE_BITS];

endmodule

`default_nettype wire

/* sv/dual_channel_trimmed_mean.sv */
// Dual channel trimmed mean: one result per WINDOW_LENGTH rows, dropping min and max.
// Throughput: one row per cycle; rows that do not close a window never stall, while the
// closing row waits until the window totals stage is free. The window's result is then
// registered through window totals, trimmed sum and reciprocal multiply.
// Reset (i_rst_n low, synchronous) clears the row counter, sums, extremes and valid bits.
`default_nettype none

`include "dual_channel_trimmed_mean_macros.svh"

module dual_channel_trimmed_mean import dctm_pkg::*; #(
    parameter int WINDOW_LENGTH = 12,
    parameter int SAMPLE_BITS   = 12
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    dctm_sample_if.sink   i_sample,
    dctm_result_if.source o_result
);

    localparam int CNTW = $clog2(WINDOW_LENGTH);
    localparam logic [CNTW-1:0] LAST_ROW = CNTW'(WINDOW_LENGTH - 1);

    logic                   r_in_vld;
    logic [SAMPLE_BITS-1:0] r_in_pulse;
    logic [SAMPLE_BITS-1:0] r_in_temp;
    logic [CNTW-1:0]        r_row_count;
    logic                   r_fin_vld;
    logic                   r_diff_vld;
    logic                   r_out_vld;

    logic      w_out_free;
    logic      w_diff_free;
    logic      w_fin_free;
    logic      w_last;
    logic      w_acc_en;
    logic      w_in_acc;
    t_pipe_ctl w_ctl;

    // stage flow: a stage moves when the next one is empty or moving
    always_comb begin
        w_out_free  = !r_out_vld || o_result.ready;
        w_diff_free = !r_diff_vld || w_out_free;
        w_fin_free  = !r_fin_vld || w_diff_free;
        w_last      = (r_row_count == LAST_ROW);
        w_acc_en    = r_in_vld && (!w_last || w_fin_free);
    end

    assign i_sample.ready = !r_in_vld || w_acc_en;
    assign w_in_acc       = i_sample.valid && i_sample.ready;

    // control bundle for both channels
    always_comb begin
        w_ctl.acc_en  = w_acc_en;
        w_ctl.last    = w_last;
        w_ctl.fin_ld  = w_acc_en && w_last;
        w_ctl.diff_ld = r_fin_vld && w_diff_free;
        w_ctl.out_ld  = r_diff_vld && w_out_free;
    end

    // valid bits and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_fin_vld   <= 1'b0;
            r_diff_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
            r_row_count <= '0;
        end else begin
            if (i_sample.ready) begin
                r_in_vld <= i_sample.valid;
            end
            if (w_fin_free) begin
                r_fin_vld <= w_ctl.fin_ld;
            end
            if (w_diff_free) begin
                r_diff_vld <= r_fin_vld;
            end
            if (w_out_free) begin
                r_out_vld <= r_diff_vld;
            end
            if (w_acc_en) begin
                r_row_count <= w_last ? '0 : r_row_count + 1'b1;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_pulse <= i_sample.pulse_sample;
            r_in_temp  <= i_sample.temp_sample;
        end
    end

    // pulse channel
    dctm_chan #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_pulse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_sample  (r_in_pulse),
        .o_average (o_result.pulse_average)
    );

    // temperature channel
    dctm_chan #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_temp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_sample  (r_in_temp),
        .o_average (o_result.temp_average)
    );

    assign o_result.valid = r_out_vld;

    // a row that does not close the window is never held back
    `DCTM_ASSERT_IMPLY(a_no_mid_stall, r_in_vld && !w_last, w_acc_en, "mid-window item stalled")
    // closing a window restarts the row count
    `DCTM_ASSERT_NEXT(a_count_wrap, w_acc_en && w_last, r_row_count == '0, "row count not cleared")
    // a blocked window total is not dropped
    `DCTM_ASSERT_NEXT(a_fin_hold, r_fin_vld && !w_fin_free, r_fin_vld, "window total lost")

endmodule

`default_nettype wire
